// ----- hw/rtl/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg - strided copy coalescer shared definitions
// Request kinds, command and event codes, register indexes and limits.
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam int ADDR_BITS_DEFAULT = 64;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [1:0] CMD_PACKET = 2'd0;
	localparam logic [1:0] CMD_FLUSH  = 2'd1;
	localparam logic [1:0] CMD_FRAME  = 2'd2;

	localparam logic [1:0] EV_ACCEPT  = 2'd0;
	localparam logic [1:0] EV_DONE    = 2'd1;
	localparam logic [1:0] EV_CORRUPT = 2'd2;
	localparam logic [1:0] EV_FRAME   = 2'd3;

	localparam logic [1:0] CFG_ROW_BYTES     = 2'd0;
	localparam logic [1:0] CFG_FRAME_BYTES   = 2'd1;
	localparam logic [1:0] CFG_FRAME_PRESENT = 2'd2;

	localparam logic [31:0] POS_MAX   = 32'hFFFF_FFFF;
	localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		KIND_NOP,
		KIND_BAD,
		KIND_PKT,
		KIND_FLUSH,
		KIND_FRAME
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] len;
	} req_t;

endpackage

// ----- hw/rtl/scc_front.sv -----
// ----------------------------------------------------------------------------
// scc_front - request intake
// Classifies each incoming request and holds it in a short queue for the
// execution side.
// ----------------------------------------------------------------------------
module scc_front #(
	parameter int ADDR_BITS = scc_pkg::ADDR_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [1:0]           cmd,
	input  logic [63:0]          src_address,
	input  logic [15:0]          packet_bytes,
	output logic                 q_valid,
	output scc_pkg::req_t        q_req,
	output logic [ADDR_BITS-1:0] q_addr,
	input  logic                 q_pop
);

	localparam int QD  = scc_pkg::QUEUE_DEPTH;
	localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW = $clog2(QD + 1);

	scc_pkg::req_t        req_mem [QD];
	logic [ADDR_BITS-1:0] addr_mem [QD];
	logic [QPW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]       cnt_q;
	logic                 push, pop;
	logic [ADDR_BITS-1:0] addr_m;
	scc_pkg::req_t        req_c;

	assign addr_m = src_address[ADDR_BITS-1:0];

	always_comb begin
		req_c.len = packet_bytes;
		case (cmd)
			scc_pkg::CMD_PACKET: begin
				req_c.kind = (addr_m == '0 || packet_bytes == '0) ?
					scc_pkg::KIND_BAD : scc_pkg::KIND_PKT;
			end
			scc_pkg::CMD_FLUSH: begin
				req_c.kind = scc_pkg::KIND_FLUSH;
			end
			scc_pkg::CMD_FRAME: begin
				req_c.kind = scc_pkg::KIND_FRAME;
			end
			default: begin
				req_c.kind = scc_pkg::KIND_NOP;
			end
		endcase
	end

	assign req_stall = (cnt_q == QCW'(QD));
	assign push      = req_valid && !req_stall;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_req     = req_mem[rd_ptr_q];
	assign q_addr    = addr_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			req_mem[wr_ptr_q]  <= req_c;
			addr_mem[wr_ptr_q] <= addr_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/scc_back.sv -----
// ----------------------------------------------------------------------------
// scc_back - run tracking and copy issue
// Holds the pending run and frame position, issues copy descriptors with
// bounds checks, and registers one result per request.
// ----------------------------------------------------------------------------
module scc_back #(
	parameter int ADDR_BITS = scc_pkg::ADDR_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 q_valid,
	input  scc_pkg::req_t        q_req,
	input  logic [ADDR_BITS-1:0] q_addr,
	output logic                 q_pop,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [1:0]           event_res,
	output logic                 copy_valid,
	output logic                 copy_two_d,
	output logic [63:0]          copy_source,
	output logic [63:0]          copy_pitch,
	output logic [15:0]          copy_width,
	output logic [31:0]          copy_rows,
	output logic [31:0]          copy_dest_offset,
	output logic [31:0]          position_after
);

	logic [15:0] row_bytes_q;
	logic [31:0] frame_bytes_q;
	logic        frame_present_q;

	logic [ADDR_BITS-1:0] first_q, last_q, stride_q;
	logic [31:0]          count_q;
	logic [47:0]          total_q;
	logic                 known_q;
	logic [31:0]          pos_q;

	logic [ADDR_BITS-1:0] first_n, last_n, stride_n;
	logic [31:0]          count_n;
	logic [47:0]          total_n;
	logic                 known_n;
	logic [31:0]          pos_n;

	logic [1:0]           ev_c;
	logic                 cv_c, c2d_c;
	logic [ADDR_BITS-1:0] csrc_c, cpitch_c;
	logic [15:0]          cwidth_c;
	logic [31:0]          crows_c, cdest_c;

	logic [ADDR_BITS-1:0] diff;
	logic [47:0]          need;
	logic [48:0]          pitch_end, pitch_adv, tot_sum;
	logic [32:0]          lin_end;
	logic                 pitch_ok, lin_ok, keep;
	logic [31:0]          pos_pitch, pos_lin, count_inc;
	logic [47:0]          total_sat;
	logic                 fire;

	assign fire  = q_valid && (!res_valid || !res_stall);
	assign q_pop = fire;

	assign diff      = q_addr - last_q;
	assign need      = 48'(row_bytes_q) * 48'(count_q);
	assign pitch_end = 49'(pos_q) + 49'(need);
	assign pitch_ok  = frame_present_q && (row_bytes_q != '0) &&
		(pitch_end <= 49'(frame_bytes_q));
	assign lin_end   = 33'(pos_q) + 33'(row_bytes_q);
	assign lin_ok    = frame_present_q && (row_bytes_q != '0) &&
		(lin_end <= 33'(frame_bytes_q));
	assign pitch_adv = 49'(pos_q) + 49'(total_q);
	assign pos_pitch = (pitch_adv > 49'(scc_pkg::POS_MAX)) ? scc_pkg::POS_MAX :
		pitch_adv[31:0];
	assign pos_lin   = lin_end[32] ? scc_pkg::POS_MAX : lin_end[31:0];
	assign count_inc = (count_q == scc_pkg::POS_MAX) ? count_q : count_q + 1'b1;
	assign tot_sum   = 49'(total_q) + 49'(q_req.len);
	assign total_sat = (tot_sum > 49'(scc_pkg::TOTAL_MAX)) ? scc_pkg::TOTAL_MAX :
		tot_sum[47:0];
	assign keep      = !known_q || (diff == stride_q);

	always_comb begin
		first_n  = first_q;
		last_n   = last_q;
		stride_n = stride_q;
		count_n  = count_q;
		total_n  = total_q;
		known_n  = known_q;
		pos_n    = pos_q;
		ev_c     = scc_pkg::EV_DONE;
		cv_c     = 1'b0;
		c2d_c    = 1'b0;
		csrc_c   = '0;
		cpitch_c = '0;
		cwidth_c = '0;
		crows_c  = '0;
		cdest_c  = '0;
		case (q_req.kind)
			scc_pkg::KIND_BAD: begin
				ev_c = scc_pkg::EV_CORRUPT;
			end
			scc_pkg::KIND_PKT: begin
				if (count_q == '0) begin
					first_n  = q_addr;
					last_n   = q_addr;
					count_n  = 32'd1;
					total_n  = 48'(q_req.len);
					known_n  = 1'b0;
					stride_n = '0;
					ev_c     = scc_pkg::EV_ACCEPT;
				end else if (keep) begin
					if (!known_q) begin
						stride_n = diff;
						known_n  = 1'b1;
					end
					last_n  = q_addr;
					count_n = count_inc;
					total_n = total_sat;
					ev_c    = scc_pkg::EV_ACCEPT;
				end else if (pitch_ok) begin
					cv_c     = 1'b1;
					c2d_c    = 1'b1;
					csrc_c   = first_q;
					cpitch_c = stride_q;
					cwidth_c = row_bytes_q;
					crows_c  = count_q;
					cdest_c  = pos_q;
					pos_n    = pos_pitch;
					first_n  = q_addr;
					last_n   = q_addr;
					count_n  = 32'd1;
					total_n  = 48'(q_req.len);
					known_n  = 1'b0;
					stride_n = '0;
					ev_c     = scc_pkg::EV_ACCEPT;
				end else begin
					first_n  = '0;
					last_n   = '0;
					count_n  = '0;
					total_n  = '0;
					known_n  = 1'b0;
					stride_n = '0;
					ev_c     = scc_pkg::EV_CORRUPT;
				end
			end
			scc_pkg::KIND_FLUSH: begin
				if (count_q == '0) begin
					ev_c = scc_pkg::EV_DONE;
				end else if (count_q != 32'd1 && known_q) begin
					if (pitch_ok) begin
						cv_c     = 1'b1;
						c2d_c    = 1'b1;
						csrc_c   = first_q;
						cpitch_c = stride_q;
						cwidth_c = row_bytes_q;
						crows_c  = count_q;
						cdest_c  = pos_q;
						pos_n    = pos_pitch;
						ev_c     = scc_pkg::EV_DONE;
					end else begin
						ev_c = scc_pkg::EV_CORRUPT;
					end
					first_n  = '0;
					last_n   = '0;
					count_n  = '0;
					total_n  = '0;
					known_n  = 1'b0;
					stride_n = '0;
				end else if (lin_ok) begin
					cv_c     = 1'b1;
					csrc_c   = first_q;
					cwidth_c = row_bytes_q;
					crows_c  = 32'd1;
					cdest_c  = pos_q;
					pos_n    = pos_lin;
					first_n  = '0;
					last_n   = '0;
					count_n  = '0;
					total_n  = '0;
					known_n  = 1'b0;
					stride_n = '0;
					ev_c     = scc_pkg::EV_DONE;
				end else begin
					ev_c = scc_pkg::EV_CORRUPT;
				end
			end
			scc_pkg::KIND_FRAME: begin
				pos_n = '0;
				ev_c  = scc_pkg::EV_FRAME;
			end
			default: begin
				ev_c = scc_pkg::EV_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q     <= '0;
			frame_bytes_q   <= '0;
			frame_present_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				scc_pkg::CFG_ROW_BYTES: begin
					row_bytes_q <= cfg_data[15:0];
				end
				scc_pkg::CFG_FRAME_BYTES: begin
					frame_bytes_q <= cfg_data;
				end
				scc_pkg::CFG_FRAME_PRESENT: begin
					frame_present_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= '0;
			last_q    <= '0;
			stride_q  <= '0;
			count_q   <= '0;
			total_q   <= '0;
			known_q   <= 1'b0;
			pos_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (fire) begin
				first_q   <= first_n;
				last_q    <= last_n;
				stride_q  <= stride_n;
				count_q   <= count_n;
				total_q   <= total_n;
				known_q   <= known_n;
				pos_q     <= pos_n;
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			event_res        <= ev_c;
			copy_valid       <= cv_c;
			copy_two_d       <= c2d_c;
			copy_source      <= 64'(csrc_c);
			copy_pitch       <= 64'(cpitch_c);
			copy_width       <= cwidth_c;
			copy_rows        <= crows_c;
			copy_dest_offset <= cdest_c;
			position_after   <= pos_n;
		end
	end

endmodule

// ----- hw/rtl/strided_copy_coalescer.sv -----
// ----------------------------------------------------------------------------
// strided_copy_coalescer - packet run coalescing into frame copy descriptors
// Gathers packets at a fixed address stride and issues pitched or linear
// copies into the frame with position tracking and bounds checks.
// ----------------------------------------------------------------------------
// Sustains one request per clock unless results stall; the combinational
// execute step (stride subtract and compare, row-times-count multiply, bounds
// compare) sets the rate. Each request gets exactly one registered result; a
// two-entry queue between intake and execution lets a stalled result block
// intake only once it is full. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module strided_copy_coalescer #(
	parameter int ADDR_BITS = scc_pkg::ADDR_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  cmd,
	input  logic [63:0] src_address,
	input  logic [15:0] packet_bytes,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  event_res,
	output logic        copy_valid,
	output logic        copy_two_d,
	output logic [63:0] copy_source,
	output logic [63:0] copy_pitch,
	output logic [15:0] copy_width,
	output logic [31:0] copy_rows,
	output logic [31:0] copy_dest_offset,
	output logic [31:0] position_after
);

	logic                 q_valid, q_pop;
	scc_pkg::req_t        q_req;
	logic [ADDR_BITS-1:0] q_addr;

	scc_front #(.ADDR_BITS(ADDR_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.src_address  (src_address),
		.packet_bytes (packet_bytes),
		.q_valid      (q_valid),
		.q_req        (q_req),
		.q_addr       (q_addr),
		.q_pop        (q_pop)
	);

	scc_back #(.ADDR_BITS(ADDR_BITS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.q_valid          (q_valid),
		.q_req            (q_req),
		.q_addr           (q_addr),
		.q_pop            (q_pop),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.event_res        (event_res),
		.copy_valid       (copy_valid),
		.copy_two_d       (copy_two_d),
		.copy_source      (copy_source),
		.copy_pitch       (copy_pitch),
		.copy_width       (copy_width),
		.copy_rows        (copy_rows),
		.copy_dest_offset (copy_dest_offset),
		.position_after   (position_after)
	);

`ifndef SYNTHESIS
	a_copy_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && copy_valid |->
			event_res == scc_pkg::EV_ACCEPT || event_res == scc_pkg::EV_DONE)
		else $error("copy issued with wrong event");

	a_no_copy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !copy_valid |->
			copy_rows == '0 && copy_width == '0 && copy_source == '0)
		else $error("copy fields set without copy");

	a_linear_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && copy_valid && !copy_two_d |->
			copy_rows == 32'd1 && copy_pitch == '0)
		else $error("bad linear copy shape");

	a_frame_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == scc_pkg::EV_FRAME |-> position_after == '0)
		else $error("frame start left position nonzero");
`endif

endmodule
